### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion helper macros
// Clocked assertion forms used by path_hierarchy_tokenizer_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, checked at every clk edge outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/pht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pht_pkg
// Types and constants of the path hierarchy tokenizer.
// ----------------------------------------------------------------------------
package pht_pkg;

	localparam int DELIM_MAX   = 4;
	localparam int RESULTS_MAX = 64;

	// configuration register indexes
	localparam logic [2:0] CFG_DELIM_BYTES = 3'd0;
	localparam logic [2:0] CFG_DELIM_LEN   = 3'd1;
	localparam logic [2:0] CFG_REPL_LEN    = 3'd2;
	localparam logic [2:0] CFG_SKIP_LEVELS = 3'd3;
	localparam logic [2:0] CFG_REVERSE     = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} pht_in_t;

	typedef struct packed {
		logic [6:0] token_start;
		logic [6:0] token_end;
		logic [8:0] converted_length;
		logic       overflow_flag;
		logic       last_token;
	} pht_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FSKIP,
		ST_FRUN,
		ST_RTRIM,
		ST_RDOWN,
		ST_RCOUNT,
		ST_RFIND
	} pht_state_t;

endpackage

### rtl/pht_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pht_store
// Byte store of the path string: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pht_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

### rtl/pht_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pht_match
// Shared delimiter compare unit: keeps the last bytes read and compares the
// window ending at the new byte against the delimiter.
// ----------------------------------------------------------------------------
module pht_match (
	input  logic        clk,
	input  logic        shift_en,
	input  logic [7:0]  rd_data,
	input  logic [31:0] delim_bytes,
	input  logic [2:0]  dlen,
	output logic        match
);
	import pht_pkg::*;

	logic [7:0] win_q [DELIM_MAX-1];
	logic [7:0] nw    [DELIM_MAX];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= rd_data;
			for (int i = 1; i < DELIM_MAX - 1; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_comb begin
		logic [2:0] sel;
		nw[0] = rd_data;
		for (int i = 1; i < DELIM_MAX; i++) begin
			nw[i] = win_q[i-1];
		end
		match = 1'b1;
		for (int j = 0; j < DELIM_MAX; j++) begin
			// byte j of the delimiter sits dlen-1-j places back
			sel = dlen - 3'd1 - 3'(j);
			if (3'(j) < dlen && nw[sel[1:0]] != delim_bytes[8*j +: 8]) begin
				match = 1'b0;
			end
		end
	end
endmodule

### rtl/path_hierarchy_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_hierarchy_tokenizer_core
// Splits a stored path string into hierarchy tokens (offset pairs).
// ----------------------------------------------------------------------------
// Usage:
//  - Bytes arrive on item with start; a word is taken when start is high and
//    busy is low. Up to MAX_LEN bytes are kept, the rest are dropped and
//    flagged as overflow.
//  - The word with end_of_string set launches the scan; busy stays high until
//    the last token has been issued.
//  - Scan: one pass over the store, one byte a cycle through the shared
//    compare unit, marking raw and non-overlapping delimiter hits. Then the
//    sequencer walks the hit bitmaps one position a cycle, forward or, with
//    reverse set, trimming levels from the end first.
//  - Each token shows on result for one cycle with result_valid; the receiver
//    cannot stall, tokens may come back to back.
//  - Config writes (cfg_wr_en/cfg_index/cfg_wdata) only while busy is low.
//  - Reset clears the fill count, overflow mark, sequencer and config to
//    their defaults; the byte store is not cleared.
// ----------------------------------------------------------------------------
module path_hierarchy_tokenizer_core #(
	parameter int MAX_LEN = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pht_pkg::pht_in_t item,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_wdata,
	output logic             result_valid,
	output pht_pkg::pht_out_t result
);
	import pht_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	// config registers
	logic [31:0] dbytes_q;
	logic [2:0]  dlen_q, rlen_q;
	logic [6:0]  skip_q;
	logic        rev_q;

	pht_state_t state_q, state_d;

	logic [CW-1:0]      cnt_q, ptr_q, base_q, we_q, nxt_q, k_q, idx_s1;
	logic               ovf_q, flag_s1;
	logic [7:0]         lv_q;
	logic [6:0]         ecnt_q;
	logic [MAX_LEN-1:0] mraw_q, dsel_q;
	pht_out_t           res_q;
	logic               res_vld_q;

	logic [2:0] eff_d, eff_r;
	logic       accept, ptr_in, dbit, mbit, match, cap_hit;
	logic [7:0] steps;
	logic [CW-1:0] dw, pos, ptr_pd;
	logic       pos_ok;
	logic [7:0] rd_data;

	// emission request
	logic          emit_en, emit_last;
	logic [CW-1:0] emit_s, emit_e, emit_k;
	logic [8:0]    conv;

	assign accept = start && (state_q == ST_IDLE);
	assign eff_d  = (dlen_q == 3'd0) ? 3'd1 : (dlen_q > 3'd4) ? 3'd4 : dlen_q;
	assign eff_r  = (rlen_q == 3'd0) ? eff_d : (rlen_q > 3'd4) ? 3'd4 : rlen_q;
	assign dw     = CW'(eff_d);
	assign ptr_in = ptr_q < cnt_q;
	assign dbit   = ptr_in && dsel_q[ptr_q[AW-1:0]];
	assign mbit   = ptr_in && mraw_q[ptr_q[AW-1:0]];
	assign steps  = {1'b0, skip_q} + {7'd0, dsel_q[0]};
	assign ptr_pd = ptr_q + dw;
	// delimiter start position for the byte just read
	assign pos_ok = ({1'b0, idx_s1} + 1'b1) >= {1'b0, dw};
	assign pos    = idx_s1 + CW'(1) - dw;

	pht_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (accept && (cnt_q < CW'(MAX_LEN))),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (item.data_byte),
		.rd_en   ((state_q == ST_SCAN) && ptr_in),
		.rd_addr (ptr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	pht_match u_match (
		.clk         (clk),
		.shift_en    (flag_s1),
		.rd_data     (rd_data),
		.delim_bytes (dbytes_q),
		.dlen        (eff_d),
		.match       (match)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.end_of_string) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!ptr_in && !flag_s1) begin
					if (rev_q) state_d = ST_RTRIM;
					else if (skip_q == 7'd0) state_d = ST_FRUN;
					else state_d = ST_FSKIP;
				end
			end
			ST_FSKIP: begin
				if (!ptr_in) state_d = ST_IDLE;
				else if (dbit && (lv_q + 8'd1) == steps) state_d = ST_FRUN;
			end
			ST_FRUN: begin
				if (cap_hit || !ptr_in) state_d = ST_IDLE;
			end
			ST_RTRIM: begin
				if (lv_q == {1'b0, skip_q}) state_d = ST_RCOUNT;
				else if (we_q <= dw) state_d = ST_IDLE;
				else state_d = ST_RDOWN;
			end
			ST_RDOWN: begin
				if (mbit) state_d = ST_RTRIM;
				else if (ptr_q == '0) state_d = ST_IDLE;
			end
			ST_RCOUNT: begin
				if (!ptr_in) state_d = ST_RFIND;
			end
			ST_RFIND: begin
				if (cap_hit || (emit_en && emit_last)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: token requests
	always_comb begin
		emit_en   = 1'b0;
		emit_last = 1'b0;
		emit_s    = base_q;
		emit_e    = ptr_q;
		emit_k    = k_q;
		case (state_q)
			ST_FRUN: begin
				if (ptr_in) begin
					emit_en = dbit;
				end else begin
					emit_en   = 1'b1;
					emit_last = 1'b1;
					emit_e    = cnt_q;
				end
			end
			ST_RFIND: begin
				emit_e = we_q;
				if (!ptr_in || dbit) begin
					emit_en   = 1'b1;
					emit_last = !(dbit && ({1'b0, ptr_pd} < {1'b0, we_q}));
				end
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	assign cap_hit = emit_en && (ecnt_q == 7'(RESULTS_MAX - 1));
	assign conv = 9'(emit_e) - 9'(emit_s) - 9'(emit_k) * 9'(eff_d)
		+ 9'(emit_k) * 9'(eff_r);
	assign busy = (state_q != ST_IDLE);
	assign result_valid = res_vld_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbytes_q <= 32'd47;
			dlen_q   <= 3'd1;
			rlen_q   <= 3'd0;
			skip_q   <= 7'd0;
			rev_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DELIM_BYTES: dbytes_q <= cfg_wdata;
				CFG_DELIM_LEN:   dlen_q   <= cfg_wdata[2:0];
				CFG_REPL_LEN:    rlen_q   <= cfg_wdata[2:0];
				CFG_SKIP_LEVELS: skip_q   <= cfg_wdata[6:0];
				CFG_REVERSE:     rev_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			flag_s1   <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= emit_en;
			if (accept) begin
				if (cnt_q < CW'(MAX_LEN)) cnt_q <= cnt_q + CW'(1);
				else ovf_q <= 1'b1;
			end
			flag_s1 <= (state_q == ST_SCAN) && ptr_in;
			if (state_q != ST_IDLE && state_d == ST_IDLE) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (emit_en) begin
			res_q.token_start      <= 7'(emit_s);
			res_q.token_end        <= 7'(emit_e);
			res_q.converted_length <= conv;
			res_q.overflow_flag    <= ovf_q;
			res_q.last_token       <= emit_last || cap_hit;
			ecnt_q                 <= ecnt_q + 7'd1;
		end
		case (state_q)
			ST_IDLE: begin
				ptr_q  <= '0;
				nxt_q  <= '0;
				mraw_q <= '0;
				dsel_q <= '0;
				lv_q   <= '0;
				ecnt_q <= '0;
			end
			ST_SCAN: begin
				if (ptr_in) ptr_q <= ptr_q + CW'(1);
				if (flag_s1 && pos_ok) begin
					mraw_q[pos[AW-1:0]] <= match;
					if (match && pos >= nxt_q) begin
						dsel_q[pos[AW-1:0]] <= 1'b1;
						nxt_q <= pos + dw;
					end
				end
				if (state_d != ST_SCAN) begin
					we_q   <= cnt_q;
					base_q <= '0;
					k_q    <= CW'(dsel_q[0]);
					ptr_q  <= (state_d == ST_FRUN) ? CW'(1) : '0;
				end
			end
			ST_FSKIP: begin
				ptr_q <= ptr_q + CW'(1);
				if (dbit) begin
					lv_q   <= lv_q + 8'd1;
					base_q <= ptr_q;
					k_q    <= CW'(1);
				end
			end
			ST_FRUN: begin
				ptr_q <= ptr_q + CW'(1);
				if (dbit) k_q <= k_q + CW'(1);
			end
			ST_RTRIM: begin
				if (lv_q == {1'b0, skip_q}) begin
					ptr_q <= '0;
					k_q   <= '0;
				end else begin
					ptr_q <= we_q - dw - CW'(1);
				end
			end
			ST_RDOWN: begin
				if (mbit) begin
					we_q <= ptr_pd;
					lv_q <= lv_q + 8'd1;
				end else begin
					ptr_q <= ptr_q - CW'(1);
				end
			end
			ST_RCOUNT: begin
				ptr_q <= ptr_q + CW'(1);
				if (dbit && ({1'b0, ptr_pd} <= {1'b0, we_q})) k_q <= k_q + CW'(1);
				if (!ptr_in) begin
					ptr_q  <= '0;
					base_q <= '0;
				end
			end
			ST_RFIND: begin
				if (ptr_in && !dbit) begin
					ptr_q <= ptr_q + CW'(1);
				end else begin
					base_q <= ptr_pd;
					ptr_q  <= ptr_pd;
					k_q    <= k_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	`ASSERT_NEXT(a_last_ends, res_vld_q && res_q.last_token, !res_vld_q)
	`ASSERT_IMPL(a_scan_nonempty, state_q == ST_SCAN, cnt_q != '0)
	`ASSERT_IMPL(a_token_order, emit_en, emit_s <= emit_e)
	`ASSERT_IMPL(a_idle_quiet, state_q == ST_IDLE, !emit_en)
endmodule
